// ===== rtl/dda_pkg.sv =====
package dda_pkg;

    localparam int CFG_BITS   = 13;
    localparam int SHIFT_BITS = 13;
    localparam int STEP_BITS  = 4;
    localparam int OP_BITS    = 4;
    localparam int COND_BITS  = 3;

    localparam logic [CFG_BITS-1:0] LIMIT_RESET = CFG_BITS'(1024);

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef logic [STEP_BITS-1:0] t_step;
    typedef logic [OP_BITS-1:0]   t_op;
    typedef logic [COND_BITS-1:0] t_cond;

    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_ACCEPT    = 4'd1;
    localparam t_op OP_LOAD      = 4'd2;
    localparam t_op OP_PIXEL     = 4'd3;
    localparam t_op OP_DELTA     = 4'd4;
    localparam t_op OP_DIV       = 4'd5;
    localparam t_op OP_UPDATE    = 4'd6;
    localparam t_op OP_EMIT      = 4'd7;
    localparam t_op OP_EMIT_ZERO = 4'd8;
    localparam t_op OP_EMIT_IDLE = 4'd9;

    localparam t_cond COND_NEVER    = 3'd0;
    localparam t_cond COND_ALWAYS   = 3'd1;
    localparam t_cond COND_ZERO_LEN = 3'd2;
    localparam t_cond COND_IDLE_ADV = 3'd3;
    localparam t_cond COND_NO_MOVE  = 3'd4;
    localparam t_cond COND_DIV_RUN  = 3'd5;

    localparam t_step S_ACCEPT    = 4'd0;
    localparam t_step S_CHK_ZERO  = 4'd1;
    localparam t_step S_CHK_IDLE  = 4'd2;
    localparam t_step S_LOAD      = 4'd3;
    localparam t_step S_PIXEL     = 4'd4;
    localparam t_step S_DELTA     = 4'd5;
    localparam t_step S_DIV       = 4'd6;
    localparam t_step S_UPDATE    = 4'd7;
    localparam t_step S_EMIT      = 4'd8;
    localparam t_step S_EMIT_ZERO = 4'd9;
    localparam t_step S_EMIT_IDLE = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: S_ACCEPT};
        case (step)
            S_ACCEPT:    w = '{op: OP_ACCEPT,    cond: COND_NEVER,    target: S_ACCEPT};
            S_CHK_ZERO:  w = '{op: OP_NOP,       cond: COND_ZERO_LEN, target: S_EMIT_ZERO};
            S_CHK_IDLE:  w = '{op: OP_NOP,       cond: COND_IDLE_ADV, target: S_EMIT_IDLE};
            S_LOAD:      w = '{op: OP_LOAD,      cond: COND_NEVER,    target: S_ACCEPT};
            S_PIXEL:     w = '{op: OP_PIXEL,     cond: COND_NEVER,    target: S_ACCEPT};
            S_DELTA:     w = '{op: OP_DELTA,     cond: COND_NO_MOVE,  target: S_UPDATE};
            S_DIV:       w = '{op: OP_DIV,       cond: COND_DIV_RUN,  target: S_DIV};
            S_UPDATE:    w = '{op: OP_UPDATE,    cond: COND_NEVER,    target: S_ACCEPT};
            S_EMIT:      w = '{op: OP_EMIT,      cond: COND_ALWAYS,   target: S_ACCEPT};
            S_EMIT_ZERO: w = '{op: OP_EMIT_ZERO, cond: COND_ALWAYS,   target: S_ACCEPT};
            S_EMIT_IDLE: w = '{op: OP_EMIT_IDLE, cond: COND_ALWAYS,   target: S_ACCEPT};
            default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: S_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/dda_div.sv =====
module dda_div import dda_pkg::*; #(
    parameter int NUM_BITS = 31,
    parameter int Q_BITS   = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [NUM_BITS-1:0] i_den,
    output logic                o_done,
    output logic [Q_BITS-1:0]   o_quot
);

    localparam int CNT_BITS = $clog2(Q_BITS);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_den;
    logic [Q_BITS-1:0]   r_quot;

    logic [NUM_BITS:0]   n_trial;
    logic                n_ge;
    logic [NUM_BITS:0]   n_diff;
    logic                n_last;

    always_comb begin
        n_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
        n_last  = r_cnt == CNT_BITS'(Q_BITS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !n_last;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[NUM_BITS-1:0] : n_trial[NUM_BITS-1:0];
            r_quot <= {r_quot[Q_BITS-2:0], n_ge};
        end
    end

    assign o_done = r_busy && n_last;
    assign o_quot = r_quot;

endmodule

// ===== rtl/dda_line_rasterizer_core.sv =====
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  request type, endpoints, shifts
// output    out        o_out_valid / i_out_stall pixel_x, pixel_y, plot, last
// config    in         i_cfg_we                 i_cfg_idx, i_cfg_data
//
// An advancing pixel runs through the accept, zero check, idle check, load,
// pixel, delta, divide, update and emit steps; the restoring divider forms
// the minor axis step. A pixel with no move left skips the divide; a zero-length
// start and an advance with no segment jump straight to their own emit steps.
// Reset is synchronous and active low; it leaves no segment and both limits at 1024.
// The next item is taken while a result waits; the emit step holds while the
// output register is full and stalled.
module dda_line_rasterizer_core import dda_pkg::*; #(
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic signed [SHIFT_BITS-1:0] i_x_shift,
    input  logic signed [SHIFT_BITS-1:0] i_y_shift,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS:0]   o_pixel_x,
    output logic signed [COORD_BITS:0]   o_pixel_y,
    output logic                         o_plot,
    output logic                         o_last,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [CFG_BITS-1:0]          i_cfg_data
);

    localparam int POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int OUT_BITS  = COORD_BITS + 1;
    localparam int MAG_BITS  = POS_BITS + 1;
    localparam int DIFF_BITS = POS_BITS + 2;
    localparam int SUM_BITS  = ((POS_BITS > SHIFT_BITS + FRAC_BITS) ?
                                POS_BITS : SHIFT_BITS + FRAC_BITS) + 2;
    localparam int INT_BITS  = SUM_BITS - FRAC_BITS + 1;
    localparam int Q_BITS    = FRAC_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] SUM_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_BITS-1:0]        MAG_HALF = MAG_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [POS_BITS:0]   POS_ONE  = (POS_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [POS_BITS-1:0] POS_MAX  = {1'b0, {(POS_BITS - 1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN  = {1'b1, {(POS_BITS - 1){1'b0}}};

    function automatic logic signed [INT_BITS-1:0] round_fx(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-1:0] mag;
        logic [SUM_BITS-1:0] rnd;
        logic [INT_BITS-1:0] ri;
        mag = v[SUM_BITS-1] ? -v : v;
        rnd = (mag + SUM_HALF) >> FRAC_BITS;
        ri  = rnd[INT_BITS-1:0];
        return v[SUM_BITS-1] ? -$signed(ri) : $signed(ri);
    endfunction

    function automatic logic inside_box(
        input logic signed [INT_BITS-1:0] px,
        input logic signed [INT_BITS-1:0] py,
        input logic [CFG_BITS-1:0]        w,
        input logic [CFG_BITS-1:0]        h
    );
        logic signed [INT_BITS-1:0] wl;
        logic signed [INT_BITS-1:0] hl;
        wl = $signed({{(INT_BITS - CFG_BITS){1'b0}}, w});
        hl = $signed({{(INT_BITS - CFG_BITS){1'b0}}, h});
        return (px > 0) && (px < wl) && (py > 0) && (py < hl);
    endfunction

    function automatic logic [MAG_BITS-1:0] abs_mag(input logic signed [DIFF_BITS-1:0] d);
        logic [DIFF_BITS-1:0] a;
        a = d[DIFF_BITS-1] ? -d : d;
        return a[MAG_BITS-1:0];
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_pos(
        input logic signed [POS_BITS:0] s
    );
        if (s[POS_BITS] != s[POS_BITS-1]) begin
            return s[POS_BITS] ? POS_MIN : POS_MAX;
        end
        return s[POS_BITS-1:0];
    endfunction

    logic [CFG_BITS-1:0]          r_width;
    logic [CFG_BITS-1:0]          r_height;
    t_step                        r_step;
    logic                         r_active;
    logic                         r_out_valid;

    logic                         r_req;
    logic signed [COORD_BITS-1:0] r_xs;
    logic signed [COORD_BITS-1:0] r_ys;
    logic signed [COORD_BITS-1:0] r_xe;
    logic signed [COORD_BITS-1:0] r_ye;
    logic signed [SHIFT_BITS-1:0] r_xsh_in;
    logic signed [SHIFT_BITS-1:0] r_ysh_in;

    logic signed [POS_BITS-1:0]   r_cur_x;
    logic signed [POS_BITS-1:0]   r_cur_y;
    logic signed [COORD_BITS-1:0] r_goal_x;
    logic signed [COORD_BITS-1:0] r_goal_y;
    logic signed [SHIFT_BITS-1:0] r_shift_x;
    logic signed [SHIFT_BITS-1:0] r_shift_y;

    logic signed [SUM_BITS-1:0]   r_vx;
    logic signed [SUM_BITS-1:0]   r_vy;
    logic signed [OUT_BITS-1:0]   r_px;
    logic signed [OUT_BITS-1:0]   r_py;
    logic                         r_plot;
    logic                         r_move;
    logic                         r_xmaj;
    logic                         r_major_pos;
    logic                         r_minor_neg;

    logic signed [OUT_BITS-1:0]   r_out_x;
    logic signed [OUT_BITS-1:0]   r_out_y;
    logic                         r_out_plot;
    logic                         r_out_last;

    t_uword                       uw;
    logic                         slot_free;
    logic                         is_emit;
    logic                         hold;
    logic                         fire;
    logic                         cond_true;
    logic                         zero_len;

    logic signed [POS_BITS-1:0]   goal_x_fx;
    logic signed [POS_BITS-1:0]   goal_y_fx;
    logic signed [DIFF_BITS-1:0]  dx;
    logic signed [DIFF_BITS-1:0]  dy;
    logic [MAG_BITS-1:0]          dx_mag;
    logic [MAG_BITS-1:0]          dy_mag;
    logic                         move;
    logic                         xmaj;
    logic signed [INT_BITS-1:0]   px_full;
    logic signed [INT_BITS-1:0]   py_full;
    logic signed [INT_BITS-1:0]   xs_full;
    logic signed [INT_BITS-1:0]   ys_full;

    logic                         div_start;
    logic                         div_done;
    logic [Q_BITS-1:0]            div_quot;
    logic [MAG_BITS-1:0]          div_num;
    logic [MAG_BITS-1:0]          div_den;

    logic signed [POS_BITS:0]     major_step;
    logic signed [POS_BITS:0]     minor_step;
    logic signed [POS_BITS:0]     sum_x;
    logic signed [POS_BITS:0]     sum_y;

    always_comb begin
        uw        = ucode(r_step);
        slot_free = !r_out_valid || !i_out_stall;
        is_emit   = (uw.op == OP_EMIT) || (uw.op == OP_EMIT_ZERO) ||
                    (uw.op == OP_EMIT_IDLE);
        hold      = ((uw.op == OP_ACCEPT) && !i_in_valid) || (is_emit && !slot_free);
        fire      = !hold;
        zero_len  = (r_req == REQ_START) && (r_xs == r_xe) && (r_ys == r_ye);

        goal_x_fx = {r_goal_x, {FRAC_BITS{1'b0}}};
        goal_y_fx = {r_goal_y, {FRAC_BITS{1'b0}}};
        dx        = DIFF_BITS'(goal_x_fx) - DIFF_BITS'(r_cur_x);
        dy        = DIFF_BITS'(goal_y_fx) - DIFF_BITS'(r_cur_y);
        dx_mag    = abs_mag(dx);
        dy_mag    = abs_mag(dy);
        move      = (dx_mag > MAG_HALF) || (dy_mag > MAG_HALF);
        xmaj      = dx_mag > dy_mag;

        px_full   = round_fx(r_vx);
        py_full   = round_fx(r_vy);
        xs_full   = INT_BITS'(r_xs);
        ys_full   = INT_BITS'(r_ys);

        div_start = (uw.op == OP_DELTA) && move;
        div_num   = xmaj ? dy_mag : dx_mag;
        div_den   = xmaj ? dx_mag : dy_mag;

        major_step = r_major_pos ? POS_ONE : -POS_ONE;
        minor_step = $signed({{(POS_BITS + 1 - Q_BITS){1'b0}}, div_quot});
        if (r_minor_neg) begin
            minor_step = -minor_step;
        end
        sum_x = (POS_BITS + 1)'(r_cur_x) + (r_xmaj ? major_step : minor_step);
        sum_y = (POS_BITS + 1)'(r_cur_y) + (r_xmaj ? minor_step : major_step);

        case (uw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_ZERO_LEN: cond_true = zero_len;
            COND_IDLE_ADV: cond_true = (r_req == REQ_ADVANCE) && !r_active;
            COND_NO_MOVE:  cond_true = !move;
            COND_DIV_RUN:  cond_true = !div_done;
            default:       cond_true = 1'b0;
        endcase
    end

    dda_div #(
        .NUM_BITS (MAG_BITS),
        .Q_BITS   (Q_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= LIMIT_RESET;
            r_height <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_ACCEPT;
        end else if (fire) begin
            r_step <= cond_true ? uw.target : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_emit && fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_shift_x <= '0;
            r_shift_y <= '0;
        end else begin
            case (uw.op)
                OP_LOAD: begin
                    if (r_req == REQ_START) begin
                        r_cur_x   <= {r_xs, {FRAC_BITS{1'b0}}};
                        r_cur_y   <= {r_ys, {FRAC_BITS{1'b0}}};
                        r_goal_x  <= r_xe;
                        r_goal_y  <= r_ye;
                        r_shift_x <= r_xsh_in;
                        r_shift_y <= r_ysh_in;
                        r_active  <= 1'b1;
                    end
                end
                OP_UPDATE: begin
                    if (r_move) begin
                        r_cur_x <= sat_pos(sum_x);
                        r_cur_y <= sat_pos(sum_y);
                    end
                end
                OP_EMIT: begin
                    if (fire) begin
                        r_active <= move;
                    end
                end
                OP_EMIT_ZERO: begin
                    r_active <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((uw.op == OP_ACCEPT) && i_in_valid) begin
            r_req    <= i_req_type;
            r_xs     <= i_x_start;
            r_ys     <= i_y_start;
            r_xe     <= i_x_end;
            r_ye     <= i_y_end;
            r_xsh_in <= i_x_shift;
            r_ysh_in <= i_y_shift;
        end
        if (uw.op == OP_PIXEL) begin
            r_vx <= SUM_BITS'(r_cur_x) + SUM_HALF + (SUM_BITS'(r_shift_x) <<< FRAC_BITS);
            r_vy <= SUM_BITS'(r_cur_y) + SUM_HALF + (SUM_BITS'(r_shift_y) <<< FRAC_BITS);
        end
        if (uw.op == OP_DELTA) begin
            r_px        <= px_full[OUT_BITS-1:0];
            r_py        <= py_full[OUT_BITS-1:0];
            r_plot      <= inside_box(px_full, py_full, r_width, r_height);
            r_move      <= move;
            r_xmaj      <= xmaj;
            r_major_pos <= xmaj ? !dx[DIFF_BITS-1] : !dy[DIFF_BITS-1];
            r_minor_neg <= xmaj ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1];
        end
        if (fire) begin
            case (uw.op)
                OP_EMIT: begin
                    r_out_x    <= r_px;
                    r_out_y    <= r_py;
                    r_out_plot <= r_plot;
                    r_out_last <= !move;
                end
                OP_EMIT_ZERO: begin
                    r_out_x    <= OUT_BITS'(r_xs);
                    r_out_y    <= OUT_BITS'(r_ys);
                    r_out_plot <= inside_box(xs_full, ys_full, r_width, r_height);
                    r_out_last <= 1'b1;
                end
                OP_EMIT_IDLE: begin
                    r_out_x    <= '0;
                    r_out_y    <= '0;
                    r_out_plot <= 1'b0;
                    r_out_last <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = uw.op != OP_ACCEPT;
    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_plot      = r_out_plot;
    assign o_last      = r_out_last;

endmodule

// ===== bench/dda_pixel_checker.sv =====
module dda_pixel_checker import dda_pkg::*; #(
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_req_type,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic signed [SHIFT_BITS-1:0] i_x_shift,
    input  logic signed [SHIFT_BITS-1:0] i_y_shift,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [COORD_BITS:0]   i_pixel_x,
    input  logic signed [COORD_BITS:0]   i_pixel_y,
    input  logic                         i_plot,
    input  logic                         i_last,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    output int                           o_fail_count,
    output int                           o_waiting,
    output int                           o_results,
    output int                           o_plotted,
    output int                           o_ends
);

    localparam longint UNIT      = longint'(1) << FRAC_BITS;
    localparam longint HALF_UNIT = longint'(1) << (FRAC_BITS - 1);
    localparam longint POS_HI    = (longint'(1) << (COORD_BITS + FRAC_BITS - 1)) - 1;
    localparam longint POS_LO    = -(longint'(1) << (COORD_BITS + FRAC_BITS - 1));

    typedef struct packed {
        logic signed [COORD_BITS:0] px;
        logic signed [COORD_BITS:0] py;
        logic                       plot;
        logic                       last;
    } t_pixel;

    logic [CFG_BITS-1:0] width_lim;
    logic [CFG_BITS-1:0] height_lim;
    longint              pos_x;
    longint              pos_y;
    longint              goal_x;
    longint              goal_y;
    longint              shift_x;
    longint              shift_y;
    logic                seg_live;
    t_pixel              expected_pixels[$];

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    function automatic longint round_half_away(input longint v);
        if (v >= 0) return (v + HALF_UNIT) >>> FRAC_BITS;
        return -(((-v) + HALF_UNIT) >>> FRAC_BITS);
    endfunction

    function automatic longint minor_step(input longint num, input longint den);
        longint rem;
        longint d;
        longint q;
        rem = mag(num);
        d   = mag(den);
        q   = 0;
        if (d == 0) return 0;
        if (rem >= d) begin
            rem -= d;
            q = 1;
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem -= d;
                q |= 1;
            end
        end
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic in_bounds(input longint px, input longint py);
        return px > 0 && px < longint'(width_lim) && py > 0 && py < longint'(height_lim);
    endfunction

    function automatic t_pixel trace_pixel(
        input logic                         req,
        input logic signed [COORD_BITS-1:0] xs,
        input logic signed [COORD_BITS-1:0] ys,
        input logic signed [COORD_BITS-1:0] xe,
        input logic signed [COORD_BITS-1:0] ye,
        input logic signed [SHIFT_BITS-1:0] sx,
        input logic signed [SHIFT_BITS-1:0] sy
    );
        t_pixel r;
        longint px;
        longint py;
        longint dx;
        longint dy;
        if (req == REQ_START) begin
            if (xs == xe && ys == ye) begin
                seg_live = 1'b0;
                px = longint'(xs);
                py = longint'(ys);
                r.px   = px[COORD_BITS:0];
                r.py   = py[COORD_BITS:0];
                r.plot = in_bounds(px, py);
                r.last = 1'b1;
                return r;
            end
            pos_x    = longint'(xs) * UNIT;
            pos_y    = longint'(ys) * UNIT;
            goal_x   = longint'(xe);
            goal_y   = longint'(ye);
            shift_x  = longint'(sx);
            shift_y  = longint'(sy);
            seg_live = 1'b1;
        end else if (!seg_live) begin
            r = '{px: '0, py: '0, plot: 1'b0, last: 1'b1};
            return r;
        end

        px = round_half_away(pos_x + HALF_UNIT + shift_x * UNIT);
        py = round_half_away(pos_y + HALF_UNIT + shift_y * UNIT);
        r.plot = in_bounds(px, py);

        dx = goal_x * UNIT - pos_x;
        dy = goal_y * UNIT - pos_y;
        if (mag(dx) > HALF_UNIT || mag(dy) > HALF_UNIT) begin
            if (mag(dx) > mag(dy)) begin
                pos_x += (dx > 0) ? UNIT : -UNIT;
                pos_y += minor_step(dy, dx);
            end else begin
                pos_y += (dy > 0) ? UNIT : -UNIT;
                pos_x += minor_step(dx, dy);
            end
            pos_x = clamp_pos(pos_x);
            pos_y = clamp_pos(pos_y);
        end
        dx = goal_x * UNIT - pos_x;
        dy = goal_y * UNIT - pos_y;
        if (!(mag(dx) > HALF_UNIT || mag(dy) > HALF_UNIT)) seg_live = 1'b0;

        r.px   = px[COORD_BITS:0];
        r.py   = py[COORD_BITS:0];
        r.last = !seg_live;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            width_lim    = LIMIT_RESET;
            height_lim   = LIMIT_RESET;
            pos_x        = 0;
            pos_y        = 0;
            goal_x       = 0;
            goal_y       = 0;
            shift_x      = 0;
            shift_y      = 0;
            seg_live     = 1'b0;
            expected_pixels.delete();
            o_fail_count = 0;
            o_waiting    = 0;
            o_results    = 0;
            o_plotted    = 0;
            o_ends       = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDTH) width_lim = i_cfg_data;
                else height_lim = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(trace_pixel(i_req_type, i_x_start, i_y_start,
                                                      i_x_end, i_y_end, i_x_shift, i_y_shift));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{px: i_pixel_x, py: i_pixel_y, plot: i_plot, last: i_last};
                o_results++;
                if (i_plot) o_plotted++;
                if (i_last) o_ends++;
                if (expected_pixels.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("Pixel transfer %0d arrived with nothing expected: x=%0d y=%0d plot=%0b last=%0b",
                                 o_results, got.px, got.py, got.plot, got.last);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.px !== want.px || got.py !== want.py ||
                        got.plot !== want.plot || got.last !== want.last) begin
                        if (o_fail_count < 10) begin
                            $display("Pixel transfer %0d differs: expected x=%0d y=%0d plot=%0b last=%0b, got x=%0d y=%0d plot=%0b last=%0b",
                                     o_results, want.px, want.py, want.plot, want.last,
                                     got.px, got.py, got.plot, got.last);
                        end
                        o_fail_count++;
                    end
                end
            end
            o_waiting = expected_pixels.size();
        end
    end

endmodule

// ===== bench/tb_dda_line_rasterizer_core.sv =====
module tb_dda_line_rasterizer_core;
    import dda_pkg::*;

    localparam int COORD_BITS = 14;
    localparam int FRAC_BITS  = 16;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         req_type  = REQ_START;
    logic signed [COORD_BITS-1:0] x_start   = '0;
    logic signed [COORD_BITS-1:0] y_start   = '0;
    logic signed [COORD_BITS-1:0] x_end     = '0;
    logic signed [COORD_BITS-1:0] y_end     = '0;
    logic signed [SHIFT_BITS-1:0] x_shift   = '0;
    logic signed [SHIFT_BITS-1:0] y_shift   = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [COORD_BITS:0]   pixel_x;
    logic signed [COORD_BITS:0]   pixel_y;
    logic                         plot;
    logic                         last;
    logic                         cfg_we    = 1'b0;
    logic [0:0]                   cfg_idx   = CFG_WIDTH;
    logic [CFG_BITS-1:0]          cfg_data  = '0;

    int   send_idle_pct  = 25;
    int   recv_stall_pct = 85;
    logic hold_on        = 1'b0;
    int   items_sent     = 0;
    event begin_hold;

    int n_fail;
    int n_waiting;
    int n_results;
    int n_plotted;
    int n_ends;

    dda_line_rasterizer_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_x_start   (x_start),
        .i_y_start   (y_start),
        .i_x_end     (x_end),
        .i_y_end     (y_end),
        .i_x_shift   (x_shift),
        .i_y_shift   (y_shift),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pixel_x   (pixel_x),
        .o_pixel_y   (pixel_y),
        .o_plot      (plot),
        .o_last      (last),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    dda_pixel_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) pixel_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_x_start    (x_start),
        .i_y_start    (y_start),
        .i_x_end      (x_end),
        .i_y_end      (y_end),
        .i_x_shift    (x_shift),
        .i_y_shift    (y_shift),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .i_plot       (plot),
        .i_last       (last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (n_fail),
        .o_waiting    (n_waiting),
        .o_results    (n_results),
        .o_plotted    (n_plotted),
        .o_ends       (n_ends)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(negedge clk);
            out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // The long hold-off of the pixel output is counted here, apart from the sender.
    initial begin
        forever begin
            @(begin_hold);
            hold_on = 1'b1;
            repeat (300) @(posedge clk);
            hold_on = 1'b0;
        end
    end

    initial begin
        #4000000;
        $display("** dda_line_rasterizer_core: FAILED **");
        $finish;
    end

    task automatic send_item(
        input logic                         req,
        input logic signed [COORD_BITS-1:0] xs,
        input logic signed [COORD_BITS-1:0] ys,
        input logic signed [COORD_BITS-1:0] xe,
        input logic signed [COORD_BITS-1:0] ye,
        input logic signed [SHIFT_BITS-1:0] sx,
        input logic signed [SHIFT_BITS-1:0] sy
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= req;
        x_start  <= xs;
        y_start  <= ys;
        x_end    <= xe;
        y_end    <= ye;
        x_shift  <= sx;
        y_shift  <= sy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_advance();
        send_item(REQ_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom),
                  SHIFT_BITS'($urandom), SHIFT_BITS'($urandom));
    endtask

    task automatic run_segment(input int xs, input int ys, input int xe, input int ye,
                               input int sx, input int sy, input int n_adv);
        send_item(REQ_START, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
                  COORD_BITS'(ye), SHIFT_BITS'(sx), SHIFT_BITS'(sy));
        repeat (n_adv) send_advance();
    endtask

    function automatic int clamp_coord(input int v);
        if (v > 8191) return 8191;
        if (v < -8192) return -8192;
        return v;
    endfunction

    function automatic int pick_coord(input logic near_screen);
        if (near_screen) return int'($urandom_range(0, 1300)) - 100;
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic int pick_shift();
        if ($urandom_range(0, 1)) return int'($urandom_range(0, 8)) - 4;
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    task automatic random_segment();
        int   pick;
        int   tail;
        int   xs;
        int   ys;
        int   xe;
        int   ye;
        int   len;
        int   n_adv;
        logic near_screen;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            send_advance();
            return;
        end
        near_screen = 1'($urandom_range(0, 1));
        xs = pick_coord(near_screen);
        ys = pick_coord(near_screen);
        if (pick < 10) begin
            xe = xs;
            ye = ys;
        end else if (pick < 18) begin
            xe = pick_coord(1'b0);
            ye = pick_coord(1'b0);
        end else begin
            xe = clamp_coord(xs + int'($urandom_range(0, 24)) - 12);
            ye = clamp_coord(ys + int'($urandom_range(0, 24)) - 12);
        end
        len = (xe > xs) ? xe - xs : xs - xe;
        if (((ye > ys) ? ye - ys : ys - ye) > len) len = (ye > ys) ? ye - ys : ys - ye;
        n_adv = (len > 0) ? len - 1 : 0;
        tail  = $urandom_range(0, 99);
        if (len > 40) n_adv = $urandom_range(0, 6);
        else if (tail < 15) n_adv = $urandom_range(0, n_adv);
        else if (tail < 25) n_adv += $urandom_range(1, 2);
        run_segment(xs, ys, xe, ye, pick_shift(), pick_shift(), n_adv);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (n_waiting == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_limits(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(25, 85);
        send_advance();
        run_segment(5, 7, 5, 7, 0, 0, 0);
        run_segment(0, 0, 0, 0, 0, 0, 0);
        run_segment(-8192, 8191, -8192, 8191, 4095, -4096, 0);
        run_segment(1, 1, 4, 1, 0, 0, 3);
        run_segment(10, 10, 10, 6, 4095, -4096, 3);
        run_segment(100, 100, 102, 105, 3, -2, 4);
        run_segment(-8192, -8192, 8191, 8191, 0, 0, 2);
        run_segment(8191, -8192, -8192, 8191, -4096, 4095, 1);
        run_segment(1022, 1, 1026, 2, 0, 0, 3);

        set_limits(8191, 8191);
        -> begin_hold;
        while (items_sent < 180) random_segment();

        set_limits(1, 8191);
        set_idling(85, 25);
        while (items_sent < 240) random_segment();

        set_limits(300, 200);
        while (items_sent < 380) random_segment();

        set_limits(0, 1);
        set_idling(0, 0);
        while (items_sent < 420) random_segment();

        set_limits(1200, 900);
        while (items_sent < 520) random_segment();
        settle();
        while (items_sent < 620) random_segment();

        settle();
        $display("Sent %0d input transfers across six limit settings, including zero and full-range bounds.",
                 items_sent);
        $display("Compared %0d pixel transfers: %0d plotted, %0d marking a segment end.",
                 n_results, n_plotted, n_ends);
        if (n_fail == 0 && n_waiting == 0) begin
            $display("** dda_line_rasterizer_core: PASSED **");
        end else begin
            $display("** dda_line_rasterizer_core: FAILED **");
        end
        $finish;
    end

endmodule
